// File: sv/ahl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ahl_pkg;

   // tree geometry
   localparam int NUM_SYMS       = 629;
   localparam int NUM_NODES      = 1258;
   localparam int END_SYM        = 256;
   localparam int LEN_CODES      = 62;
   localparam int NUM_SLOTS      = 6;
   localparam int NODE_W         = 11;
   localparam int WEIGHT_W       = 16;
   localparam int TREE_DEPTH     = 2048;
   localparam int WINDOW_DEFAULT = 32768;
   localparam int QUEUE_DEPTH    = 4;

   // register reset values and indexes
   localparam logic [14:0] RESCALE_RESET = 15'd2000;
   localparam logic [31:0] MAX_OUT_RESET = 32'h2000_0000;
   localparam logic        CSR_RESCALE   = 1'b0;
   localparam logic        CSR_MAX_OUT   = 1'b1;

   // status codes
   localparam logic [1:0] ST_RUN   = 2'd0;
   localparam logic [1:0] ST_END   = 2'd1;
   localparam logic [1:0] ST_TRUNC = 2'd2;
   localparam logic [1:0] ST_LIMIT = 2'd3;

   typedef struct packed {
      logic coded_bit;
      logic last_bit;
   } req_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       run_end;
      logic [1:0] status;
   } rsp_type;

   typedef struct packed {
      logic clearing;
      logic halted;
   } eng_stat_type;

   typedef enum logic [1:0] {
      PH_SYM,
      PH_EXTRA,
      PH_HALT
   } phase_type;

   typedef enum logic {
      RET_BUMP,
      RET_SWAP
   } ret_type;

   typedef enum logic [5:0] {
      S_CLR, S_IDLE, S_WALK, S_SYM, S_EXTRA, S_ESET, S_CRD, S_CWR, S_END, S_FIN,
      S_B0, S_B1, S_B2,
      S_LA, S_LB, S_LC, S_LD, S_LE, S_LF, S_LG, S_H0, S_H1,
      S_SA, S_SB, S_SC, S_SD, S_SE, S_SF, S_SG, S_SH, S_SI, S_SN, S_SO, S_SP
   } state_type;

   // distance base of each slot
   function automatic logic [12:0] slot_base(input logic [2:0] k);
      logic [12:0] b;
      case (k)
         3'd0:    b = 13'd0;
         3'd1:    b = 13'd16;
         3'd2:    b = 13'd80;
         3'd3:    b = 13'd336;
         3'd4:    b = 13'd1360;
         default: b = 13'd5456;
      endcase
      return b;
   endfunction

endpackage
`default_nettype wire

// File: sv/adaptive_huffman_lz77_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// Decodes one coded bit per item. A bit that ends no symbol goes through the
// walk, end and finish states to its result, and the next item starts after it.
// A decoded symbol adds the leaf bump, a lift per tree level and swap steps up
// the tree with a lift per exchange. Each byte is a window read, then a write
// and push. A weight halving sweep reads and halves each node. Reset (synchronous)
// starts a pass that writes the initial tree; req_full stays high during it.
module adaptive_huffman_lz77_decoder #(
   parameter int WINDOW_BYTES = ahl_pkg::WINDOW_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   input  wire ahl_pkg::req_type req_data,
   output logic                  req_full,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output ahl_pkg::rsp_type      rsp_data,
   input  wire logic             csr_we,
   input  wire logic             csr_index,
   input  wire logic [31:0]      csr_wdata
);
   import ahl_pkg::*;

   logic [14:0]  rescale_ff;
   logic [31:0]  maxout_ff;
   logic         in_full, in_empty, in_pop, out_full, out_push;
   req_type      in_head;
   rsp_type      out_item;
   eng_stat_type stat;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rescale_ff <= RESCALE_RESET;
         maxout_ff  <= MAX_OUT_RESET;
      end else if (csr_we) begin
         if (csr_index == CSR_RESCALE) rescale_ff <= csr_wdata[14:0];
         if (csr_index == CSR_MAX_OUT) maxout_ff  <= csr_wdata;
      end
   end

   assign req_full = in_full || stat.clearing;

   ahl_fifo #(.WIDTH($bits(req_type)), .DEPTH(QUEUE_DEPTH)) u_in_q (
      .clock, .reset, .push(req_push && !req_full), .wdata(req_data), .full(in_full),
      .pop(in_pop), .rdata(in_head), .empty(in_empty));

   ahl_engine #(.WINDOW_BYTES(WINDOW_BYTES)) u_engine (
      .clock, .reset, .in_valid(!in_empty), .in_data(in_head), .in_pop,
      .out_full, .out_push, .out_data(out_item),
      .rescale_limit(rescale_ff), .max_out(maxout_ff), .stat);

   ahl_fifo #(.WIDTH($bits(rsp_type)), .DEPTH(QUEUE_DEPTH)) u_out_q (
      .clock, .reset, .push(out_push), .wdata(out_item), .full(out_full),
      .pop(rsp_pop), .rdata(rsp_data), .empty(rsp_empty));

   // reset leads into the tree clearing pass
   a_clear_after_reset: assert property (@(posedge clock) reset |=> req_full)
      else $error("input not held off after reset");
   // nothing is produced while the tree is being cleared
   a_no_rsp_in_clear: assert property (@(posedge clock) stat.clearing |-> rsp_empty)
      else $error("result during clearing pass");
   // a halted stream stays halted until reset
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      stat.halted |=> stat.halted)
      else $error("halt released");
endmodule
`default_nettype wire

// File: sv/ahl_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module ahl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end
endmodule
`default_nettype wire

// File: sv/ahl_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module ahl_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] rdata,
   output logic                  empty
);
   localparam int AW = $clog2(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [AW:0]      cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full    = (cnt_ff == (AW+1)'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign rdata   = mem_ff[rptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // pointer and fill count
   always_comb begin
      wptr_in = do_push ? ((wptr_ff == AW'(DEPTH-1)) ? '0 : wptr_ff + 1'b1) : wptr_ff;
      rptr_in = do_pop ? ((rptr_ff == AW'(DEPTH-1)) ? '0 : rptr_ff + 1'b1) : rptr_ff;
      cnt_in  = cnt_ff + (AW+1)'(do_push) - (AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
      if (do_push) begin
         mem_ff[wptr_ff] <= wdata;
      end
   end
endmodule
`default_nettype wire

// File: sv/ahl_engine.sv
`timescale 1ns / 1ps
`default_nettype none
module ahl_engine #(
   parameter int WINDOW_BYTES = ahl_pkg::WINDOW_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   input  wire ahl_pkg::req_type      in_data,
   output logic                       in_pop,
   input  wire logic                  out_full,
   output logic                       out_push,
   output ahl_pkg::rsp_type           out_data,
   input  wire logic [14:0]           rescale_limit,
   input  wire logic [31:0]           max_out,
   output ahl_pkg::eng_stat_type      stat
);
   import ahl_pkg::*;

   localparam int AW = $clog2(WINDOW_BYTES);
   localparam int TW = $clog2(TREE_DEPTH);

   state_type state_ff, state_in;
   ret_type   ret_ff, ret_in;
   phase_type phase_ff, phase_in;
   logic [1:0]          halt_ff, halt_in;
   logic [NODE_W-1:0]   walk_ff, walk_in, sym_ff, sym_in, node_ff, node_in;
   logic [NODE_W-1:0]   lnode_ff, lnode_in, lsib_ff, lsib_in, wpos_ff, wpos_in;
   logic [NODE_W-1:0]   gp_ff, gp_in, un_ff, un_in, other_ff, other_in;
   logic [NODE_W-1:0]   lguard_ff, lguard_in, sguard_ff, sguard_in, hidx_ff, hidx_in;
   logic [TW-1:0]       clr_ff, clr_in;
   logic [WEIGHT_W-1:0] wa_ff, wa_in, wu_ff, wu_in;
   logic                fstw_ff, fstw_in, bit_ff, bit_in, last_ff, last_in;
   logic [2:0]          k_ff, k_in;
   logic [6:0]          len_ff, len_in, rem_ff, rem_in;
   logic [13:0]         extra_ff, extra_in;
   logic [3:0]          ecnt_ff, ecnt_in;
   logic [AW-1:0]       pos_ff, pos_in, src_ff, src_in;
   logic                wrap_ff, wrap_in, lit_ff, lit_in, srcok_ff, srcok_in;
   logic [7:0]          litb_ff, litb_in;
   logic [31:0]         bout_ff, bout_in;

   // tree and window memory ports
   logic                w_we, p_we, l_we, r_we, h_we;
   logic [TW-1:0]       w_wa, w_ra, p_wa, p_ra, l_wa, l_ra, r_wa, r_ra;
   logic [WEIGHT_W-1:0] w_wd, w_q;
   logic [NODE_W-1:0]   p_wd, p_q, l_wd, l_q, r_wd, r_q;
   logic [AW-1:0]       h_wa, h_ra;
   logic [7:0]          h_wd, h_q;

   ahl_ram #(.WIDTH(WEIGHT_W), .DEPTH(TREE_DEPTH)) u_weights (
      .clock, .we(w_we), .waddr(w_wa), .wdata(w_wd), .raddr(w_ra), .rdata(w_q));
   ahl_ram #(.WIDTH(NODE_W), .DEPTH(TREE_DEPTH)) u_parent (
      .clock, .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_q));
   ahl_ram #(.WIDTH(NODE_W), .DEPTH(TREE_DEPTH)) u_left (
      .clock, .we(l_we), .waddr(l_wa), .wdata(l_wd), .raddr(l_ra), .rdata(l_q));
   ahl_ram #(.WIDTH(NODE_W), .DEPTH(TREE_DEPTH)) u_right (
      .clock, .we(r_we), .waddr(r_wa), .wdata(r_wd), .raddr(r_ra), .rdata(r_q));
   ahl_ram #(.WIDTH(8), .DEPTH(WINDOW_BYTES)) u_window (
      .clock, .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_q));

   assign stat.clearing = (state_ff == S_CLR);
   assign stat.halted   = (phase_ff == PH_HALT);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         phase_ff <= PH_SYM;
         halt_ff  <= ST_RUN;
         walk_ff  <= NODE_W'(1);
         clr_ff   <= '0;
         extra_ff <= '0;
         ecnt_ff  <= '0;
         pos_ff   <= '0;
         wrap_ff  <= 1'b0;
         bout_ff  <= '0;
         k_ff     <= '0;
         len_ff   <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         halt_ff  <= halt_in;
         walk_ff  <= walk_in;
         clr_ff   <= clr_in;
         extra_ff <= extra_in;
         ecnt_ff  <= ecnt_in;
         pos_ff   <= pos_in;
         wrap_ff  <= wrap_in;
         bout_ff  <= bout_in;
         k_ff     <= k_in;
         len_ff   <= len_in;
      end
      ret_ff   <= ret_in;
      sym_ff   <= sym_in;
      node_ff  <= node_in;
      lnode_ff <= lnode_in;
      lsib_ff  <= lsib_in;
      wpos_ff  <= wpos_in;
      gp_ff    <= gp_in;
      un_ff    <= un_in;
      other_ff <= other_in;
      lguard_ff <= lguard_in;
      sguard_ff <= sguard_in;
      hidx_ff  <= hidx_in;
      wa_ff    <= wa_in;
      wu_ff    <= wu_in;
      fstw_ff  <= fstw_in;
      bit_ff   <= bit_in;
      last_ff  <= last_in;
      rem_ff   <= rem_in;
      src_ff   <= src_in;
      lit_ff   <= lit_in;
      srcok_ff <= srcok_in;
      litb_ff  <= litb_in;
   end

   // sequencer: walk, tree update, extra bits, copy
   always_comb begin
      logic [NODE_W-1:0] child, sib, s11;
      logic [9:0]        sdiff;
      logic [8:0]        x;
      logic [2:0]        kx;
      logic [15:0]       shifted;
      logic [16:0]       span;
      logic [31:0]       avail;
      logic              ok, cut;
      logic [1:0]        st;

      state_in = state_ff;  ret_in = ret_ff;  phase_in = phase_ff;  halt_in = halt_ff;
      walk_in = walk_ff;  sym_in = sym_ff;  node_in = node_ff;  lnode_in = lnode_ff;
      lsib_in = lsib_ff;  wpos_in = wpos_ff;  gp_in = gp_ff;  un_in = un_ff;
      other_in = other_ff;  lguard_in = lguard_ff;  sguard_in = sguard_ff;
      hidx_in = hidx_ff;  clr_in = clr_ff;  wa_in = wa_ff;  wu_in = wu_ff;
      fstw_in = fstw_ff;  bit_in = bit_ff;  last_in = last_ff;  k_in = k_ff;
      len_in = len_ff;  rem_in = rem_ff;  extra_in = extra_ff;  ecnt_in = ecnt_ff;
      pos_in = pos_ff;  src_in = src_ff;  wrap_in = wrap_ff;  lit_in = lit_ff;
      srcok_in = srcok_ff;  litb_in = litb_ff;  bout_in = bout_ff;

      w_we = 1'b0;  w_wa = '0;  w_wd = '0;  w_ra = '0;
      p_we = 1'b0;  p_wa = '0;  p_wd = '0;  p_ra = '0;
      l_we = 1'b0;  l_wa = '0;  l_wd = '0;  l_ra = '0;
      r_we = 1'b0;  r_wa = '0;  r_wd = '0;  r_ra = '0;
      h_we = 1'b0;  h_wa = pos_ff;  h_wd = '0;  h_ra = src_ff;

      in_pop   = 1'b0;
      out_push = 1'b0;
      st       = (phase_ff == PH_HALT) ? halt_ff : ST_RUN;
      out_data = '{data_byte: 8'd0, has_byte: 1'b0, run_end: 1'b1, status: st};

      child   = bit_ff ? r_q : l_q;
      sib     = '0;
      s11     = sym_ff - NODE_W'(NUM_SYMS);
      sdiff   = s11[9:0] - 10'(END_SYM + 1);
      x       = sdiff[8:0];
      kx      = '0;
      for (int i = 1; i < NUM_SLOTS; i++) begin
         if (x >= 9'(LEN_CODES * i)) kx = 3'(i);
      end
      shifted = 16'(bit_ff) << ecnt_ff;
      span    = 17'(extra_ff) + 17'(len_ff) + 17'(slot_base(k_ff));
      ok      = (bout_ff < max_out);
      avail   = max_out - bout_ff;
      cut     = !ok || (avail < 32'(len_ff));

      unique case (state_ff)
         // initial tree image, one entry per cycle
         S_CLR: begin
            w_we = 1'b1;  p_we = 1'b1;  l_we = 1'b1;  r_we = 1'b1;
            w_wa = clr_ff;  p_wa = clr_ff;  l_wa = clr_ff;  r_wa = clr_ff;
            w_wd = (clr_ff >= TW'(2) && clr_ff < TW'(NUM_NODES)) ? WEIGHT_W'(1) : '0;
            p_wd = (clr_ff < TW'(NUM_NODES)) ? NODE_W'(clr_ff >> 1) : '0;
            l_wd = (clr_ff >= TW'(1) && clr_ff < TW'(NUM_SYMS)) ? NODE_W'({clr_ff, 1'b0}) : '0;
            r_wd = (clr_ff >= TW'(1) && clr_ff < TW'(NUM_SYMS)) ? NODE_W'({clr_ff, 1'b1}) : '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == '1) state_in = S_IDLE;
         end
         S_IDLE: begin
            l_ra = walk_ff;  r_ra = walk_ff;
            if (in_valid) begin
               in_pop  = 1'b1;
               bit_in  = in_data.coded_bit;
               last_in = in_data.last_bit;
               unique case (phase_ff)
                  PH_SYM:   state_in = S_WALK;
                  PH_EXTRA: state_in = S_EXTRA;
                  default:  state_in = S_FIN;
               endcase
            end
         end
         S_WALK: begin
            if (child >= NODE_W'(NUM_SYMS)) begin
               sym_in  = (child >= NODE_W'(NUM_NODES)) ? NODE_W'(NUM_NODES - 1) : child;
               node_in = sym_in;
               walk_in = NODE_W'(1);
               state_in = S_B0;
            end else begin
               walk_in  = child;
               state_in = S_END;
            end
         end
         // weight bump of the decoded leaf
         S_B0: begin
            w_ra = node_ff;  p_ra = node_ff;
            state_in = S_B1;
         end
         S_B1: begin
            w_we = 1'b1;  w_wa = node_ff;  w_wd = w_q + 1'b1;
            wpos_in = p_q;
            l_ra = p_q;  r_ra = p_q;
            state_in = (p_q == NODE_W'(1)) ? S_SYM : S_B2;
         end
         S_B2: begin
            sib = (l_q == node_ff) ? r_q : l_q;
            lnode_in = node_ff;  lsib_in = sib;  lguard_in = '0;  ret_in = RET_BUMP;
            state_in = S_LA;
         end
         // weight propagation toward the root
         S_LA: begin
            p_ra = lnode_ff;  w_ra = lnode_ff;
            state_in = S_LB;
         end
         S_LB: begin
            lnode_in = p_q;  wa_in = w_q;  w_ra = lsib_ff;
            state_in = S_LC;
         end
         S_LC: begin
            w_we = 1'b1;  w_wa = lnode_ff;  w_wd = wa_ff + w_q;
            lguard_in = lguard_ff + 1'b1;
            p_ra = lnode_ff;
            if (lnode_ff == NODE_W'(1) || lguard_ff >= NODE_W'(NUM_NODES)) state_in = S_LF;
            else state_in = S_LD;
         end
         S_LD: begin
            l_ra = p_q;  r_ra = p_q;
            state_in = S_LE;
         end
         S_LE: begin
            lsib_in = (l_q == lnode_ff) ? r_q : l_q;
            state_in = S_LA;
         end
         S_LF: begin
            w_ra = TW'(1);
            state_in = S_LG;
         end
         S_LG: begin
            if (w_q == WEIGHT_W'(rescale_limit)) begin
               hidx_in  = NODE_W'(1);
               state_in = S_H0;
            end else if (ret_ff == RET_BUMP) begin
               sguard_in = '0;
               state_in  = S_SA;
            end else begin
               state_in = S_SI;
            end
         end
         // halve all weights, read then write back
         S_H0: begin
            w_ra = hidx_ff;
            state_in = S_H1;
         end
         S_H1: begin
            w_we = 1'b1;  w_wa = hidx_ff;  w_wd = w_q >> 1;
            hidx_in = hidx_ff + 1'b1;
            if (hidx_ff == NODE_W'(NUM_NODES - 1)) begin
               if (ret_ff == RET_BUMP) begin
                  sguard_in = '0;
                  state_in  = S_SA;
               end else begin
                  state_in = S_SI;
               end
            end else begin
               state_in = S_H0;
            end
         end
         // swap with lighter uncle, walking up
         S_SA: begin
            p_ra = wpos_ff;
            state_in = S_SB;
         end
         S_SB: begin
            gp_in = p_q;  l_ra = p_q;  r_ra = p_q;
            state_in = S_SC;
         end
         S_SC: begin
            fstw_in = (wpos_ff == l_q);
            un_in   = fstw_in ? r_q : l_q;
            w_ra    = un_in;
            state_in = S_SD;
         end
         S_SD: begin
            wu_in = w_q;  w_ra = node_ff;
            state_in = S_SE;
         end
         S_SE: begin
            if (wu_ff < w_q) begin
               if (fstw_ff) begin
                  r_we = 1'b1;  r_wa = gp_ff;  r_wd = node_ff;
               end else begin
                  l_we = 1'b1;  l_wa = gp_ff;  l_wd = node_ff;
               end
               state_in = S_SF;
            end else begin
               state_in = S_SN;
            end
         end
         S_SF: begin
            l_ra = wpos_ff;  r_ra = wpos_ff;
            state_in = S_SG;
         end
         S_SG: begin
            if (node_ff == l_q) begin
               other_in = r_q;
               l_we = 1'b1;  l_wa = wpos_ff;  l_wd = un_ff;
            end else begin
               other_in = l_q;
               r_we = 1'b1;  r_wa = wpos_ff;  r_wd = un_ff;
            end
            p_we = 1'b1;  p_wa = un_ff;  p_wd = wpos_ff;
            state_in = S_SH;
         end
         S_SH: begin
            p_we = 1'b1;  p_wa = node_ff;  p_wd = gp_ff;
            lnode_in = un_ff;  lsib_in = other_ff;  lguard_in = '0;  ret_in = RET_SWAP;
            state_in = S_LA;
         end
         S_SI: begin
            node_in  = un_ff;
            state_in = S_SN;
         end
         S_SN: begin
            p_ra = node_ff;
            state_in = S_SO;
         end
         S_SO: begin
            node_in = p_q;  p_ra = p_q;
            state_in = S_SP;
         end
         S_SP: begin
            wpos_in   = p_q;
            sguard_in = sguard_ff + 1'b1;
            if (p_q != NODE_W'(1) && sguard_ff < NODE_W'(NUM_NODES)) state_in = S_SA;
            else state_in = S_SYM;
         end
         // symbol class
         S_SYM: begin
            if (s11 < NODE_W'(END_SYM)) begin
               lit_in = 1'b1;  litb_in = s11[7:0];  len_in = 7'd1;
               state_in = S_ESET;
            end else if (s11 == NODE_W'(END_SYM)) begin
               halt_in = ST_END;  phase_in = PH_HALT;
               state_in = S_END;
            end else begin
               k_in     = kx;
               len_in   = 7'(x - 9'(kx) * 9'(LEN_CODES) + 9'd3);
               extra_in = '0;  ecnt_in = '0;  phase_in = PH_EXTRA;
               state_in = S_END;
            end
         end
         S_EXTRA: begin
            extra_in = extra_ff | shifted[13:0];
            ecnt_in  = ecnt_ff + 1'b1;
            if ({1'b0, ecnt_in} >= 5'({k_ff, 1'b0}) + 5'd4) begin
               phase_in = PH_SYM;  ecnt_in = '0;  lit_in = 1'b0;
               state_in = S_ESET;
            end else begin
               state_in = S_END;
            end
         end
         // final status is known before the bytes go out
         S_ESET: begin
            src_in = pos_ff - AW'(span);
            if (cut) begin
               halt_in = ST_LIMIT;  phase_in = PH_HALT;
               rem_in  = ok ? avail[6:0] : 7'd0;
            end else begin
               rem_in = len_ff;
               if (last_ff) begin
                  halt_in = ST_TRUNC;  phase_in = PH_HALT;
               end
            end
            state_in = (rem_in == '0) ? S_FIN : S_CRD;
         end
         S_CRD: begin
            srcok_in = wrap_ff || (src_ff < pos_ff);
            state_in = S_CWR;
         end
         S_CWR: begin
            if (!out_full) begin
               out_push = 1'b1;
               out_data.data_byte = lit_ff ? litb_ff : (srcok_ff ? h_q : 8'd0);
               out_data.has_byte  = 1'b1;
               out_data.run_end   = (rem_ff == 7'd1);
               h_we = 1'b1;  h_wd = out_data.data_byte;
               pos_in  = pos_ff + 1'b1;
               if (pos_ff == '1) wrap_in = 1'b1;
               bout_in = bout_ff + 1'b1;
               src_in  = src_ff + 1'b1;
               rem_in  = rem_ff - 1'b1;
               state_in = (rem_ff == 7'd1) ? S_IDLE : S_CRD;
            end
         end
         S_END: begin
            if (last_ff && phase_ff != PH_HALT) begin
               halt_in = ST_TRUNC;  phase_in = PH_HALT;
            end
            state_in = S_FIN;
         end
         S_FIN: begin
            if (!out_full) begin
               out_push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule
`default_nettype wire

// File: tb/adaptive_huffman_lz77_decoder_test.sv
`timescale 1ns / 1ps
module adaptive_huffman_lz77_decoder_test;
   import ahl_pkg::*;

   localparam int unsigned LM       = 32'h7FF;
   localparam int unsigned WMASK    = 32'h7FFF;
   localparam int unsigned NSYM     = 629;
   localparam int unsigned NNODE    = 1258;
   localparam int unsigned SYM_END  = 256;
   localparam int unsigned NLEN     = 62;
   localparam int          WDOG_MAX = 400000;
   localparam int          SETTLE   = 3000;

   logic        clock;
   logic        reset;
   logic        req_push;
   req_type     req_data;
   logic        req_full;
   logic        rsp_empty;
   logic        rsp_pop;
   rsp_type     rsp_data;
   logic        csr_we;
   logic        csr_index;
   logic [31:0] csr_wdata;

   adaptive_huffman_lz77_decoder dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_data(req_data), .req_full(req_full),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // shadow of the decoder state
   bit [15:0]   tree_wt [2048];
   bit [15:0]   tree_up [2048];
   bit [15:0]   tree_lo [2048];
   bit [15:0]   tree_hi [2048];
   bit [7:0]    hist [32768];
   int unsigned wpos, walk, ph, xval, xcnt, psym, nout, hcode;
   int unsigned lim_rescale, lim_out;
   byte unsigned step_bytes[$];

   req_type     bits_pending[$];
   rsp_type     bytes_expected[$];
   int          errors;
   int          sent_cnt;
   int          pushed;
   bit          steady;
   int          quiet_cycles;

   // clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic void shadow_reset();
      for (int i = 0; i < 2048; i++) begin
         tree_wt[i] = 0;
         tree_up[i] = 0;
         tree_lo[i] = 0;
         tree_hi[i] = 0;
      end
      for (int i = 2; i < NNODE; i++) begin
         tree_wt[i] = 1;
         tree_up[i] = i >> 1;
      end
      for (int i = 1; i < NSYM; i++) begin
         tree_lo[i] = i * 2;
         tree_hi[i] = i * 2 + 1;
      end
      for (int i = 0; i < 32768; i++) hist[i] = 0;
      wpos = 0; walk = 1; ph = 0; xval = 0; xcnt = 0;
      psym = 0; nout = 0; hcode = 0;
      lim_rescale = 2000;
      lim_out = 32'h2000_0000;
   endfunction

   // recompute ancestor weights from n upward, then halve on limit
   function automatic void lift_weights(int unsigned n, int unsigned s);
      int unsigned guard, p, g;
      guard = 0;
      forever begin
         p = n;
         n = tree_up[n & LM];
         tree_wt[n & LM] = tree_wt[p & LM] + tree_wt[s & LM];
         guard++;
         if (n == 1 || guard > NNODE) break;
         g = tree_up[n & LM];
         s = tree_lo[g & LM];
         if (s == n) s = tree_hi[g & LM];
      end
      if (tree_wt[1] == lim_rescale)
         for (int i = 1; i < NNODE; i++) tree_wt[i] = tree_wt[i] >> 1;
   endfunction

   // weight increment plus uncle swaps
   function automatic void bump_leaf(int unsigned n);
      int unsigned p, s, w, g, fst, un, other, guard;
      guard = 0;
      tree_wt[n & LM] = tree_wt[n & LM] + 1;
      p = tree_up[n & LM];
      if (p == 1) return;
      s = tree_lo[p & LM];
      if (s == n) s = tree_hi[p & LM];
      lift_weights(n, s);
      w = p;
      do begin
         g = tree_up[w & LM];
         fst = tree_lo[g & LM];
         un = (w == fst) ? tree_hi[g & LM] : fst;
         if (tree_wt[un & LM] < tree_wt[n & LM]) begin
            if (w == fst) tree_hi[g & LM] = n;
            else tree_lo[g & LM] = n;
            other = tree_lo[w & LM];
            if (n == other) begin
               other = tree_hi[w & LM];
               tree_lo[w & LM] = un;
            end else begin
               tree_hi[w & LM] = un;
            end
            tree_up[un & LM] = w;
            tree_up[n & LM] = g;
            lift_weights(un, other);
            n = un;
         end
         n = tree_up[n & LM];
         w = tree_up[n & LM];
         guard++;
      end while (w != 1 && guard <= NNODE);
   endfunction

   function automatic void put_byte(bit [7:0] v);
      if (ph >= 2) return;
      if (nout >= lim_out) begin
         hcode = ST_LIMIT;
         ph = 2;
         return;
      end
      hist[wpos & WMASK] = v;
      wpos = (wpos + 1) & WMASK;
      nout++;
      step_bytes.push_back(v);
   endfunction

   function automatic void copy_match();
      int unsigned s, len, k, base, src;
      s = psym - SYM_END - 1;
      len = s % NLEN + 3;
      k = s / NLEN;
      base = 0;
      for (int unsigned i = 0; i < k && i < 6; i++) base += 1 << (i * 2 + 4);
      src = wpos - (xval + len + base);
      while (len != 0 && ph < 2) begin
         len--;
         put_byte(hist[src & WMASK]);
         src = (src & WMASK) + 1;
      end
   endfunction

   // one coded bit in, expected output bytes appended
   function automatic void decode_bit(req_type it);
      int unsigned b, n, s, need;
      bit [1:0] st;
      rsp_type r;
      b = it.coded_bit;
      step_bytes.delete();
      if (ph == 0) begin
         n = (b ? tree_hi[walk & LM] : tree_lo[walk & LM]) & LM;
         if (n >= NSYM) begin
            if (n >= NNODE) n = NNODE - 1;
            walk = 1;
            bump_leaf(n);
            s = n - NSYM;
            if (s < SYM_END) begin
               put_byte(s[7:0]);
            end else if (s == SYM_END) begin
               hcode = ST_END;
               ph = 2;
            end else begin
               psym = s;
               xval = 0;
               xcnt = 0;
               ph = 1;
            end
         end else begin
            walk = n;
         end
      end else if (ph == 1) begin
         need = ((psym - SYM_END - 1) / NLEN) * 2 + 4;
         xval = (xval | (b << (xcnt & 15))) & 32'h3FFF;
         xcnt++;
         if (xcnt >= need) begin
            ph = 0;
            copy_match();
            xcnt = 0;
         end
      end
      if (it.last_bit && ph < 2) begin
         hcode = ST_TRUNC;
         ph = 2;
      end
      st = (ph >= 2) ? hcode[1:0] : ST_RUN;
      if (step_bytes.size() == 0) begin
         r = '{data_byte: 8'd0, has_byte: 1'b0, run_end: 1'b1, status: st};
         bytes_expected.push_back(r);
      end
      foreach (step_bytes[k]) begin
         r.data_byte = step_bytes[k];
         r.has_byte  = 1'b1;
         r.run_end   = (k == step_bytes.size() - 1);
         r.status    = st;
         bytes_expected.push_back(r);
      end
   endfunction

   // sender: feeds pending bits, updates the shadow on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            decode_bit(bits_pending.pop_front());
            sent_cnt++;
         end
         if (bits_pending.size() != 0 && (steady || $urandom_range(99) >= 37)) begin
            req_push <= 1'b1;
            req_data <= bits_pending[0];
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // receiver: checks each popped item, with one long hold-off
   int  hold_left;
   bit  hold_done;
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (bytes_expected.size() == 0) begin
            errors++;
            $display("%0t: unexpected item byte=%h has=%b end=%b st=%0d", $time,
                     rsp_data.data_byte, rsp_data.has_byte, rsp_data.run_end,
                     rsp_data.status);
         end else begin
            rsp_type e;
            e = bytes_expected.pop_front();
            if (rsp_data.data_byte !== e.data_byte || rsp_data.has_byte !== e.has_byte ||
                rsp_data.run_end !== e.run_end || rsp_data.status !== e.status) begin
               errors++;
               $display("%0t: mismatch expected byte=%h has=%b end=%b st=%0d", $time,
                        e.data_byte, e.has_byte, e.run_end, e.status);
               $display("%0t:          actual   byte=%h has=%b end=%b st=%0d", $time,
                        rsp_data.data_byte, rsp_data.has_byte, rsp_data.run_end,
                        rsp_data.status);
            end
         end
      end
      if (!hold_done && sent_cnt >= 90) begin
         hold_done = 1;
         hold_left = 300;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= steady || $urandom_range(99) >= 37;
      end
   end

   // watchdog on cycles with no traffic at all
   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || reset)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WDOG_MAX) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic csr_write(logic idx, logic [31:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_RESCALE) lim_rescale = val & 32'h7FFF;
      else lim_out = val;
   endtask

   // wait until every expected item has arrived and the block is quiet
   task automatic drain();
      while (bits_pending.size() != 0 || bytes_expected.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic add_bit(bit b, bit last);
      bits_pending.push_back('{coded_bit: b, last_bit: last});
      pushed++;
   endtask

   // bring the shadow to the start of a symbol walk
   task automatic settle_walk();
      while (bits_pending.size() != 0) @(negedge clock);
      while (ph < 2 && (ph != 0 || walk != 1)) begin
         add_bit($urandom_range(1), 1'b0);
         while (bits_pending.size() != 0) @(negedge clock);
      end
   endtask

   // encode one symbol from the current tree, plus its extra bits
   task automatic send_symbol(int unsigned sym, int unsigned extra);
      bit path[$];
      int unsigned n, p, k;
      n = sym + NSYM;
      for (int g = 0; g < 2048 && n != 1; g++) begin
         p = tree_up[n & LM];
         path.push_front(tree_hi[p & LM] == n);
         n = p;
      end
      foreach (path[i]) add_bit(path[i], 1'b0);
      if (sym > SYM_END) begin
         k = (sym - SYM_END - 1) / NLEN;
         for (int unsigned i = 0; i < k * 2 + 4; i++) add_bit((extra >> i) & 1, 1'b0);
      end
   endtask

   task automatic random_stream(int goal);
      int unsigned slot, sym;
      while (pushed < goal) begin
         settle_walk();
         if (ph >= 2) break;
         if ($urandom_range(99) < 8) begin
            repeat ($urandom_range(1, 6)) add_bit($urandom_range(1), 1'b0);
         end else if ($urandom_range(99) < 45) begin
            send_symbol($urandom_range(255), 0);
         end else begin
            slot = ($urandom_range(99) < 70) ? $urandom_range(1) : $urandom_range(2, 5);
            sym = SYM_END + 1 + slot * NLEN + $urandom_range(NLEN - 1);
            send_symbol(sym, $urandom());
         end
      end
   endtask

   initial begin
      shadow_reset();
      reset     = 1'b1;
      req_push  = 1'b0;
      req_data  = '0;
      rsp_pop   = 1'b0;
      csr_we    = 1'b0;
      csr_index = CSR_RESCALE;
      csr_wdata = '0;
      errors = 0; sent_cnt = 0; pushed = 0; steady = 0;
      quiet_cycles = 0; hold_left = 0; hold_done = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // extremes of both registers, then literal and match edges
      csr_write(CSR_RESCALE, 32'd32767);
      csr_write(CSR_MAX_OUT, 32'hFFFF_FFFF);
      @(negedge clock);
      settle_walk();
      send_symbol(0, 0);
      settle_walk();
      send_symbol(255, 0);
      settle_walk();
      send_symbol(SYM_END + 1, 0);
      settle_walk();
      send_symbol(NSYM - 1, 32'h3FFF);
      drain();

      // limit just above the root weight so halving fires
      csr_write(CSR_RESCALE, (tree_wt[1] + 3) & 32'h7FFF);
      @(negedge clock);
      random_stream(140);
      drain();

      // lowest limit, no idling on either side
      csr_write(CSR_RESCALE, 32'd2);
      csr_write(CSR_MAX_OUT, MAX_OUT_RESET);
      @(negedge clock);
      steady = 1;
      random_stream(230);
      drain();
      steady = 0;

      csr_write(CSR_RESCALE, RESCALE_RESET);
      @(negedge clock);
      random_stream(380);
      drain();

      // output limit at its minimum halts on the next byte
      csr_write(CSR_MAX_OUT, 32'd1);
      @(negedge clock);
      for (int i = 0; i < 40 && ph < 2; i++) begin
         settle_walk();
         if (ph < 2) send_symbol($urandom_range(255), 0);
      end
      // ignored bits after halt
      repeat (15) add_bit($urandom_range(1), $urandom_range(1));
      add_bit($urandom_range(1), 1'b1);
      drain();

      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
